// ----- sv/sbpm_pkg.sv -----
// Shared types, constants and register codes of the spectrum band peak meter.
`timescale 1ns / 1ps
`default_nettype none
package sbpm_pkg;

    // Default sizes handed to the top level parameters, and the queue depth
    localparam int BAND_COUNT_DEF = 8;
    localparam int FRAME_BINS_DEF = 512;
    localparam int MAG_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH    = 4;

    // Fixed field widths
    localparam int BAND_BITS  = 3;
    localparam int LEVEL_BITS = 24;
    localparam int DRIVE_BITS = 10;
    localparam int EDGE_BITS  = 8;
    localparam int GAIN_BITS  = 6;
    localparam int WGT_BITS   = 9;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = 24'hFF_FFFF;
    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = 10'd1023;
    localparam logic [WGT_BITS-1:0]   WEIGHT_FULL = 9'd256;

    // level * 1023 / 50 reaches 1024 from this level up
    localparam logic [LEVEL_BITS-1:0] DRIVE_SAT_LEVEL = 24'd51;
    // level * 1023 / 50 reads full scale from this level up
    localparam logic [LEVEL_BITS-1:0] DRIVE_FULL_LEVEL = 24'd50;
    localparam int DRIVE_SCALE = 1023;
    localparam int DRIVE_DIV   = 50;
    // ceil(1023 * 2^16 / 50): exact floor of level * 1023 / 50 for levels up to 50
    localparam int DRIVE_RECIP_SHIFT = 16;
    localparam int DRIVE_RECIP_BITS  = 21;
    localparam int DRIVE_RECIP = ((DRIVE_SCALE << DRIVE_RECIP_SHIFT) + DRIVE_DIV - 1) / DRIVE_DIV;
    // gain is in tenths and the store in Q.8: 10 * 256 = 5 * 2^9
    localparam int LEVEL_PRE_SHIFT = 9;
    localparam int LEVEL_ODD_DIV   = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_GAINS  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_EDGES = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_END     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WEIGHT      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOISE_FLOOR = 3'd4;

    // Configuration reset values
    localparam logic [47:0] GAINS_RST  = 48'd44678567731850;
    localparam logic [63:0] EDGES_RST  = 64'd12357971021029639425;
    localparam logic [7:0]  TOP_RST    = 8'd213;
    localparam logic [8:0]  WEIGHT_RST = 9'd243;
    localparam logic [23:0] FLOOR_RST  = 24'd20;

    typedef struct packed {
        logic [47:0]           gains;
        logic [63:0]           edges;
        logic [EDGE_BITS-1:0]  top_end;
        logic [WGT_BITS-1:0]   weight;
        logic [LEVEL_BITS-1:0] floor_level;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULA,
        ST_MULB,
        ST_SUM,
        ST_GAIN,
        ST_RECIP,
        ST_LEVEL,
        ST_SCALE,
        ST_OUT
    } t_back_state;

endpackage
`default_nettype wire

// ----- sv/sbpm_front.sv -----
// Front part: bin counting, band tracking and running peak, one bin per cycle while the queue is not full.
`timescale 1ns / 1ps
`default_nettype none
module sbpm_front #(
    parameter int BAND_COUNT = 8,
    parameter int FRAME_BINS = 512,
    parameter int MAG_BITS   = 24
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  [sbpm_pkg::LEVEL_BITS-1:0]       i_mag,
    input  wire                                   i_last,
    input  sbpm_pkg::t_cfg                        i_cfg,
    input  wire                                   i_q_full,
    output logic                                  o_push,
    output logic [sbpm_pkg::BAND_BITS+MAG_BITS-1:0] o_push_data
);
    import sbpm_pkg::*;

    localparam int CW   = $clog2(FRAME_BINS);
    localparam int CMPW = (CW > EDGE_BITS) ? CW : EDGE_BITS;
    localparam int CURW = $clog2(BAND_COUNT + 1);

    logic [CW-1:0]       r_bin;
    logic [CURW-1:0]     r_cursor;
    logic [MAG_BITS-1:0] r_peak;

    logic [MAG_BITS-1:0]  mag;
    logic [CMPW-1:0]      b;
    logic [BAND_BITS-1:0] c3;
    logic [BAND_BITS-1:0] nc3;
    logic [CURW-1:0]      nc;
    logic [EDGE_BITS-1:0] st_c;
    logic [EDGE_BITS-1:0] st_n;
    logic [EDGE_BITS-1:0] end_c;
    logic                 last_band;
    logic                 active;
    logic                 close;
    logic                 next_started;
    logic                 frame_end;
    logic                 accept;
    logic [MAG_BITS-1:0]  pk;

    always_comb begin
        mag       = MAG_BITS'(i_mag);
        b         = CMPW'(r_bin);
        c3        = BAND_BITS'(r_cursor);
        nc        = r_cursor + CURW'(1);
        nc3       = BAND_BITS'(nc);
        st_c      = i_cfg.edges[EDGE_BITS*c3 +: EDGE_BITS];
        st_n      = i_cfg.edges[EDGE_BITS*nc3 +: EDGE_BITS];
        last_band = nc >= CURW'(BAND_COUNT);
        end_c     = last_band ? i_cfg.top_end : st_n;
        active    = r_cursor < CURW'(BAND_COUNT);
        pk        = (active && b >= CMPW'(st_c) && mag > r_peak) ? mag : r_peak;
        close     = active && (b == CMPW'(end_c));
        next_started = !last_band && (b >= CMPW'(st_n));
        frame_end = i_last || (r_bin >= CW'(FRAME_BINS - 1));
        o_ready   = !i_q_full;
        accept    = i_valid && o_ready;
        o_push    = accept && close;
        o_push_data = {c3, pk};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin    <= '0;
            r_cursor <= '0;
            r_peak   <= '0;
        end else if (accept) begin
            if (frame_end) begin
                r_bin    <= '0;
                r_cursor <= '0;
                r_peak   <= '0;
            end else begin
                r_bin <= r_bin + CW'(1);
                if (close) begin
                    // restart the peak with this bin if the next band already began
                    r_cursor <= nc;
                    r_peak   <= next_started ? mag : '0;
                end else begin
                    r_peak <= pk;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- sv/sbpm_fifo.sv -----
// Short queue of closed bands between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module sbpm_fifo #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [NW-1:0]    r_cnt;

    logic do_push;
    logic do_pop;

    always_comb begin
        o_valid = r_cnt != '0;
        o_full  = r_cnt == NW'(DEPTH);
        o_data  = r_mem[r_rd];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/sbpm_back.sv -----
// Back part: smoothing, gain, noise floor and drive scaling with reciprocal division.
`timescale 1ns / 1ps
`default_nettype none
module sbpm_back #(
    parameter int BAND_COUNT = 8,
    parameter int MAG_BITS   = 24
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  sbpm_pkg::t_cfg                          i_cfg,
    input  wire                                     i_q_valid,
    input  wire  [sbpm_pkg::BAND_BITS+MAG_BITS-1:0] i_q_data,
    output logic                                    o_q_pop,
    output logic                                    o_valid,
    input  wire                                     i_ready,
    output logic [sbpm_pkg::BAND_BITS-1:0]          o_band,
    output logic [sbpm_pkg::LEVEL_BITS-1:0]         o_level,
    output logic [sbpm_pkg::DRIVE_BITS-1:0]         o_drive
);
    import sbpm_pkg::*;

    localparam int SW   = MAG_BITS + 8;
    localparam int PW   = SW + GAIN_BITS;
    localparam int BIW  = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
    // divide the shifted product by five through a rounded-up reciprocal
    localparam int YW   = PW - LEVEL_PRE_SHIFT;
    localparam int RS   = YW + $clog2(LEVEL_ODD_DIV);
    localparam int MW   = RS + 1 - $clog2(LEVEL_ODD_DIV);
    localparam int PRW  = YW + MW;
    localparam int QUOW = (YW - 2 > LEVEL_BITS) ? YW - 2 : LEVEL_BITS + 1;
    localparam logic [MW-1:0] LVL_RECIP =
        MW'(((64'd1 << RS) + 64'(LEVEL_ODD_DIV - 1)) / 64'(LEVEL_ODD_DIV));
    localparam int DPW  = GAIN_BITS + DRIVE_RECIP_BITS;

    t_back_state r_state;
    t_back_state n_state;

    logic [BAND_BITS-1:0]  r_band;
    logic [MAG_BITS-1:0]   r_peak;
    logic [SW-1:0]         r_pa;
    logic [SW+8:0]         r_pb;
    logic [SW-1:0]         r_store [BAND_COUNT];
    logic [PW-1:0]         r_prod;
    logic [QUOW-1:0]       r_quo;
    logic [LEVEL_BITS-1:0] r_level;
    logic [DRIVE_BITS-1:0] r_drive;
    logic                  r_out_valid;
    logic [BAND_BITS-1:0]  r_out_band;
    logic [LEVEL_BITS-1:0] r_out_level;
    logic [DRIVE_BITS-1:0] r_out_drive;

    logic [WGT_BITS-1:0]   w;
    logic [WGT_BITS-1:0]   inv_w;
    logic [SW-1:0]         old_sm;
    logic [SW-1:0]         sm;
    logic [GAIN_BITS-1:0]  gain;
    logic [PRW-1:0]        lvl_prod;
    logic [LEVEL_BITS-1:0] lvl_sat;
    logic [DPW-1:0]        drv_prod;
    logic [DRIVE_BITS-1:0] drv_q;
    logic                  load_out;

    always_comb begin
        w        = (i_cfg.weight > WEIGHT_FULL) ? WEIGHT_FULL : i_cfg.weight;
        inv_w    = WEIGHT_FULL - w;
        old_sm   = r_store[r_band[BIW-1:0]];
        sm       = r_pa + SW'(r_pb >> 8);
        gain     = i_cfg.gains[GAIN_BITS*r_band +: GAIN_BITS];
        lvl_prod = PRW'(r_prod[PW-1:LEVEL_PRE_SHIFT]) * PRW'(LVL_RECIP);
        lvl_sat  = (|r_quo[QUOW-1:LEVEL_BITS]) ? LEVEL_MAX : r_quo[LEVEL_BITS-1:0];
        drv_prod = DPW'(r_level[GAIN_BITS-1:0]) * DPW'(DRIVE_RECIP);
        drv_q    = DRIVE_BITS'(drv_prod >> DRIVE_RECIP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = ST_MULA;
                end
            end
            ST_MULA:  n_state = ST_MULB;
            ST_MULB:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_GAIN;
            ST_GAIN:  n_state = ST_RECIP;
            ST_RECIP: n_state = ST_LEVEL;
            ST_LEVEL: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_OUT;
            ST_OUT: begin
                // hold here until the output register is free
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_band <= i_q_data[BAND_BITS+MAG_BITS-1:MAG_BITS];
                r_peak <= i_q_data[MAG_BITS-1:0];
            end
            ST_MULA:  r_pa <= SW'((MAG_BITS+WGT_BITS)'(r_peak) * (MAG_BITS+WGT_BITS)'(w));
            ST_MULB:  r_pb <= (SW+9)'(old_sm) * (SW+9)'(inv_w);
            ST_SUM:   r_pa <= sm;
            ST_GAIN:  r_prod <= PW'(r_pa) * PW'(gain);
            ST_RECIP: r_quo <= QUOW'(lvl_prod >> RS);
            ST_LEVEL: begin
                r_level <= (lvl_sat < i_cfg.floor_level) ? '0 : lvl_sat;
            end
            ST_SCALE: begin
                r_drive <= (r_level >= DRIVE_SAT_LEVEL) ? DRIVE_MAX : drv_q;
            end
            default: begin
            end
        endcase
    end

    // smoothed values, cleared at reset, updated once per band closing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BAND_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else if (r_state == ST_SUM) begin
            r_store[r_band[BIW-1:0]] <= sm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_band  <= r_band;
            r_out_level <= r_level;
            r_out_drive <= r_drive;
        end
    end

    assign o_valid = r_out_valid;
    assign o_band  = r_out_band;
    assign o_level = r_out_level;
    assign o_drive = r_out_drive;

endmodule
`default_nettype wire

// ----- sv/spectrum_band_peak_meter.sv -----
// Top level of the spectrum band peak meter: configuration registers and part wiring.
//
// Channel   Dir  Fields (lowest bit up)                     Handshake
// s_axis    in   tdata: magnitude[23:0]; tlast: last_bin     tvalid/tready
// m_axis    out  tdata: adjusted_level[23:0], drive_level    tvalid/tready
//                [33:24]; tuser: band_index[2:0]
// i_cfg     in   i_cfg_idx selects register, i_cfg_data      i_cfg_we
//
// The front takes one bin per cycle; it stalls only while the queue of four band
// closings is full. The back takes one closing at a time: a pop, seven stages of
// smoothing, gain, reciprocal division and drive scaling, and the output load. A stalled
// output register holds the back and, through the queue, the front. Synchronous reset
// clears counters, queue, output register and the smoothing store.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_band_peak_meter #(
    parameter int BAND_COUNT = sbpm_pkg::BAND_COUNT_DEF,
    parameter int FRAME_BINS = sbpm_pkg::FRAME_BINS_DEF,
    parameter int MAG_BITS   = sbpm_pkg::MAG_BITS_DEF
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire  [23:0]                            s_axis_tdata,  // magnitude[23:0]
    input  wire                                    s_axis_tlast,  // last_bin
    output logic                                   m_axis_tvalid,
    input  wire                                    m_axis_tready,
    output logic [39:0]                            m_axis_tdata,  // adjusted_level, drive_level
    output logic [2:0]                             m_axis_tuser,  // band_index
    input  wire                                    i_cfg_we,
    input  wire  [sbpm_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  wire  [sbpm_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);
    import sbpm_pkg::*;

    localparam int QW = BAND_BITS + MAG_BITS;

    t_cfg r_cfg;

    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_data;

    logic [LEVEL_BITS-1:0] out_level;
    logic [DRIVE_BITS-1:0] out_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gains       <= GAINS_RST;
            r_cfg.edges       <= EDGES_RST;
            r_cfg.top_end     <= TOP_RST;
            r_cfg.weight      <= WEIGHT_RST;
            r_cfg.floor_level <= FLOOR_RST;
        end else if (i_cfg_we) begin
            // drop writes to indexes beyond the register list
            unique case (i_cfg_idx)
                CFG_BAND_GAINS:  r_cfg.gains       <= i_cfg_data[47:0];
                CFG_START_EDGES: r_cfg.edges       <= i_cfg_data;
                CFG_TOP_END:     r_cfg.top_end     <= i_cfg_data[EDGE_BITS-1:0];
                CFG_WEIGHT:      r_cfg.weight      <= i_cfg_data[WGT_BITS-1:0];
                CFG_NOISE_FLOOR: r_cfg.floor_level <= i_cfg_data[LEVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    sbpm_front #(
        .BAND_COUNT (BAND_COUNT),
        .FRAME_BINS (FRAME_BINS),
        .MAG_BITS   (MAG_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_mag       (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    sbpm_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_data)
    );

    sbpm_back #(
        .BAND_COUNT (BAND_COUNT),
        .MAG_BITS   (MAG_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_band    (m_axis_tuser),
        .o_level   (out_level),
        .o_drive   (out_drive)
    );

    assign m_axis_tdata = {6'b0, out_drive, out_level};

endmodule
`default_nettype wire

// ----- sv/sbpm_checker.sv -----
// Port-level checks of the spectrum band peak meter and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbpm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_m_tvalid,
    input wire        i_m_tready,
    input wire [39:0] i_m_tdata,
    input wire [2:0]  i_m_tuser
);
    import sbpm_pkg::*;

    // a stalled result keeps its band and levels
    a_hold_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid right after reset");

    // drive reads full scale exactly from the full-scale level up
    a_drive_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((i_m_tdata[23:0] >= DRIVE_FULL_LEVEL) == (i_m_tdata[33:24] == DRIVE_MAX)))
        else $error("drive saturation does not match level");

    // a zero level drives nothing
    a_zero_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[23:0] == '0 |-> i_m_tdata[33:24] == '0)
        else $error("nonzero drive for zero level");

endmodule

bind spectrum_band_peak_meter sbpm_checker u_sbpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
`default_nettype wire
